@@ rtl/cas_pkg.sv @@
// shared types, codes and constants for the cascade anticollision/select sequencer
// used by cas_crc, the sequencer top and the testbench; no dependencies
package cas_pkg;

    localparam logic       KIND_START  = 1'b0;
    localparam logic       ACT_FRAME   = 1'b0;
    localparam logic       ACT_FINISH  = 1'b1;

    // reply status codes
    localparam logic [2:0] RS_OK       = 3'd0;
    localparam logic [2:0] RS_COLL     = 3'd1;
    localparam logic [2:0] RS_TIMEOUT  = 3'd2;
    localparam logic [2:0] RS_ERROR    = 3'd3;
    localparam logic [2:0] RS_NOROOM   = 3'd4;
    // codes above no room are undefined and end the selection as an error
    localparam logic [2:0] RS_RESERVED = 3'd7;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_COLL     = 3'd1;
    localparam logic [2:0] ST_INTERNAL = 3'd2;
    localparam logic [2:0] ST_ERROR    = 3'd3;
    localparam logic [2:0] ST_CRC      = 3'd4;
    localparam logic [2:0] ST_TIMEOUT  = 3'd5;
    localparam logic [2:0] ST_NOROOM   = 3'd6;
    localparam logic [2:0] ST_BADARG   = 3'd7;

    // select commands of the three cascade levels
    localparam logic [7:0]  CMD_SEL_CL1 = 8'h93;
    localparam logic [7:0]  CMD_SEL_CL2 = 8'h95;
    localparam logic [7:0]  CMD_SEL_CL3 = 8'h97;

    localparam logic [7:0]  TAG_CT     = 8'h88;
    localparam logic [7:0]  NVB_SELECT = 8'h70;
    localparam logic [7:0]  MAX_BITS   = 8'd80;
    localparam logic [5:0]  FULL_BITS  = 6'd32;
    localparam logic [15:0] CRC_PRESET = 16'h6363;
    localparam logic [15:0] CRC_POLY   = 16'h8408;

    typedef struct packed {
        logic        kind;
        logic [7:0]  start_known_bits;
        logic [3:0]  start_uid_size;
        logic [63:0] start_uid_head;
        logic [15:0] start_uid_tail;
        logic [2:0]  reply_status;
        logic [7:0]  reply_coll_reg;
        logic [55:0] reply_bytes;
        logic [2:0]  reply_count;
        logic [2:0]  reply_last_bits;
    } in_t;

    typedef struct packed {
        logic        action;
        logic [63:0] frame_head;
        logic [7:0]  frame_tail;
        logic [3:0]  frame_bytes;
        logic [2:0]  tx_last_bits;
        logic [2:0]  rx_align;
        logic [2:0]  rx_room;
        logic [2:0]  status;
        logic [63:0] uid_head;
        logic [15:0] uid_tail;
        logic [3:0]  uid_size;
        logic [7:0]  sak;
    } out_t;

    typedef struct packed {
        logic init;
        logic shift;
        logic din;
    } crc_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_COPY, S_RESOLVE, S_SETUP, S_EMIT,
        S_CRC, S_CRC_END, S_SAK_CRC, S_SAK_CHK, S_OUT
    } state_t;

endpackage

@@ rtl/cas_crc.sv @@
// bit-serial crc_a register, one data bit per cycle while shift is set, lsb first
// depends on cas_pkg
module cas_crc (
    input  logic              clk,
    input  logic              rst_n,
    input  cas_pkg::crc_ctl_t ctl,
    output logic [15:0]       crc
);
    import cas_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.init)
        begin
            crc_next = CRC_PRESET;
        end
        else if (ctl.shift)
        begin
            crc_next = (crc_reg >> 1) ^ ((crc_reg[0] ^ ctl.din) ? CRC_POLY : 16'h0000);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_PRESET;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

@@ rtl/cascade_anticollision_select_top.sv @@
// cascade anticollision and select sequencer, reader side
// depends on cas_pkg and cas_crc
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | in_data  (cas_pkg::in_t)
//  result  | out_valid | out_stall | out_data (cas_pkg::out_t)
//
// one item at a time; in_stall is high from the transfer until the block is idle again
// a start passes decode, setup and emit, an anticollision reply decode,
// copy, resolve and emit; a rejected start or a reply ending in decode goes to S_OUT
// a select frame adds the serial crc_a over seven bytes and a state to store it
// a sak reply adds the serial crc_a check of its sak byte; a level
// change goes on through the setup and frame of the next level
// in_reg, out_reg are not reset; a result held by out_stall keeps the block in S_OUT
module cascade_anticollision_select_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  cas_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output cas_pkg::out_t out_data
);
    import cas_pkg::*;

    state_t      state_reg, state_next;
    in_t         in_reg;
    out_t        out_reg;
    out_t        out_next;
    logic        out_valid_reg;
    logic        busy_reg;
    logic [1:0]  level_reg;
    logic [5:0]  lkb_reg;
    logic [7:0]  frame_reg [9];
    logic [7:0]  uid_reg [10];
    logic [3:0]  exp_reg;
    logic [2:0]  slb_reg;
    logic [7:0]  sbits_reg;
    logic [2:0]  cidx_reg;
    logic [55:0] rx_sh_reg;
    logic [5:0]  ccnt_reg;
    logic        res_act_reg;
    logic [2:0]  res_st_reg;
    logic [3:0]  res_size_reg;
    logic [7:0]  res_sak_reg;

    crc_ctl_t    crc_ctl;
    logic [15:0] crc;

    cas_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .crc   (crc)
    );

    // decisions shared by next state and datapath
    logic        sel_full;
    logic [3:0]  off;
    logic [2:0]  room;
    logic        dec_fin;
    logic [2:0]  dec_st;
    logic [5:0]  pos;
    logic        res_fin;
    logic [2:0]  res_st;
    logic [3:0]  base;
    logic        slot_free;
    logic        sak_bad_crc;

    always_comb
    begin
        sel_full = lkb_reg >= FULL_BITS;
        off      = sel_full ? 4'd6 : 4'd2 + {1'b0, lkb_reg[5:3]};
        room     = sel_full ? 3'd3 : 3'(4'd9 - off);
        base     = (level_reg == 2'd1) ? 4'd0 : ((level_reg == 2'd2) ? 4'd3 : 4'd6);
        pos      = (in_reg.reply_coll_reg[4:0] == 5'd0) ? FULL_BITS
                                                        : {1'b0, in_reg.reply_coll_reg[4:0]};
        dec_fin = 1'b1;
        dec_st  = ST_ERROR;
        if (in_reg.kind == KIND_START)
        begin
            dec_fin = in_reg.start_known_bits > MAX_BITS;
            dec_st  = ST_BADARG;
        end
        else
        begin
            case (in_reg.reply_status)
                RS_TIMEOUT: dec_st = ST_TIMEOUT;
                RS_NOROOM:  dec_st = ST_NOROOM;
                RS_OK, RS_COLL:
                begin
                    dec_fin = in_reg.reply_count > room;
                    dec_st  = ST_NOROOM;
                end
                default:    dec_st = ST_ERROR;
            endcase
        end
        res_fin = 1'b0;
        res_st  = ST_ERROR;
        if (in_reg.reply_status == RS_COLL)
        begin
            if (in_reg.reply_coll_reg[5])
            begin
                res_fin = 1'b1;
                res_st  = ST_COLL;
            end
            else if (pos <= lkb_reg)
            begin
                res_fin = 1'b1;
                res_st  = ST_INTERNAL;
            end
        end
        else if (sel_full)
        begin
            res_fin = (in_reg.reply_count != 3'd3) || (slb_reg != 3'd0);
            res_st  = ST_ERROR;
        end
        slot_free   = !out_valid_reg || !out_stall;
        sak_bad_crc = (frame_reg[7] != crc[7:0]) || (frame_reg[8] != crc[15:8]);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_DECODE;
            S_DECODE:
            begin
                if (in_reg.kind == KIND_START)
                    state_next = dec_fin ? S_OUT : S_SETUP;
                else if (!busy_reg)
                    state_next = S_IDLE;
                else
                    state_next = dec_fin ? S_OUT : S_COPY;
            end
            S_COPY:    if (cidx_reg == in_reg.reply_count) state_next = S_RESOLVE;
            S_RESOLVE:
            begin
                if (res_fin)
                    state_next = S_OUT;
                else if (in_reg.reply_status == RS_COLL || !sel_full)
                    state_next = S_EMIT;
                else
                    state_next = S_SAK_CRC;
            end
            S_SETUP:   state_next = S_EMIT;
            S_EMIT:    state_next = sel_full ? S_CRC : S_OUT;
            S_CRC:     if (ccnt_reg == 6'd55) state_next = S_CRC_END;
            S_CRC_END: state_next = S_OUT;
            S_SAK_CRC: if (ccnt_reg == 6'd7) state_next = S_SAK_CHK;
            S_SAK_CHK:
            begin
                if (!sak_bad_crc && frame_reg[6][2] && level_reg < 2'd3)
                    state_next = S_SETUP;
                else
                    state_next = S_OUT;
            end
            S_OUT:     if (slot_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        in_stall      = (state_reg != S_IDLE);
        crc_ctl.init  = 1'b0;
        crc_ctl.shift = 1'b0;
        crc_ctl.din   = 1'b0;
        case (state_reg)
            S_EMIT:    crc_ctl.init = 1'b1;
            S_RESOLVE: crc_ctl.init = 1'b1;
            S_CRC:
            begin
                crc_ctl.shift = 1'b1;
                crc_ctl.din   = frame_reg[{1'b0, ccnt_reg[5:3]}][ccnt_reg[2:0]];
            end
            S_SAK_CRC:
            begin
                crc_ctl.shift = 1'b1;
                crc_ctl.din   = frame_reg[6][ccnt_reg[2:0]];
            end
            default:   crc_ctl.shift = 1'b0;
        endcase
    end

    // level setup values
    logic       ct;
    logic [6:0] known;
    logic [6:0] known_ct;
    logic [3:0] nb;
    logic [7:0] cmd;
    logic [7:0] setup_frame [9];
    always_comb
    begin
        if (level_reg == 2'd1)
            ct = (sbits_reg != 8'd0) && (exp_reg > 4'd4);
        else if (level_reg == 2'd2)
            ct = (sbits_reg != 8'd0) && (exp_reg > 4'd7);
        else
            ct = 1'b0;
        known    = (sbits_reg > {1'b0, base, 3'b000}) ? 7'(sbits_reg - {1'b0, base, 3'b000})
                                                      : 7'd0;
        nb       = 4'(known[6:3]) + {3'b000, known[2:0] != 3'd0};
        if (nb > (ct ? 4'd3 : 4'd4))
            nb = ct ? 4'd3 : 4'd4;
        known_ct = ct ? known + 7'd8 : known;
        if (known_ct > 7'd32)
            known_ct = 7'd32;
        cmd = (level_reg == 2'd1) ? CMD_SEL_CL1
                                  : ((level_reg == 2'd2) ? CMD_SEL_CL2 : CMD_SEL_CL3);
        for (int i = 0; i < 9; i++) setup_frame[i] = 8'h00;
        setup_frame[0] = cmd;
        if (ct)
            setup_frame[2] = TAG_CT;
        for (int i = 0; i < 4; i++)
        begin
            if (4'(i) < nb)
                setup_frame[(ct ? 3 : 2) + i] = uid_reg[base + 4'(i)];
        end
    end

    logic [7:0] cmask;
    logic [3:0] widx;
    logic [3:0] pidx;
    logic [2:0] pbit;
    logic [3:0] fidx;
    logic [3:0] used;
    logic [2:0] tx;
    always_comb
    begin
        cmask = 8'hFF << slb_reg;
        widx  = off + {1'b0, cidx_reg};
        pidx  = 4'd1 + {1'b0, pos[5:3]} + {3'b000, pos[2:0] != 3'd0};
        pbit  = 3'(pos - 6'd1);
        fidx  = 4'd2 + {1'b0, lkb_reg[5:3]};
        tx    = sel_full ? 3'd0 : lkb_reg[2:0];
        used  = sel_full ? 4'd9 : fidx + {3'b000, tx != 3'd0};
    end

    // result word loaded into the output register
    always_comb
    begin
        out_next        = '0;
        out_next.action = res_act_reg;
        if (res_act_reg == ACT_FRAME)
        begin
            for (int i = 0; i < 8; i++)
                out_next.frame_head[8*i +: 8] = (4'(i) < used) ? frame_reg[i] : 8'h00;
            out_next.frame_tail   = (used == 4'd9) ? frame_reg[8] : 8'h00;
            out_next.frame_bytes  = used;
            out_next.tx_last_bits = tx;
            out_next.rx_align     = tx;
            out_next.rx_room      = room;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
                out_next.uid_head[8*i +: 8] = uid_reg[i];
            out_next.uid_tail = {uid_reg[9], uid_reg[8]};
            out_next.status   = res_st_reg;
            out_next.uid_size = res_size_reg;
            out_next.sak      = res_sak_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            level_reg     <= 2'd1;
            lkb_reg       <= 6'd0;
            exp_reg       <= 4'd0;
            slb_reg       <= 3'd0;
            sbits_reg     <= 8'd0;
            cidx_reg      <= 3'd0;
            ccnt_reg      <= 6'd0;
            res_act_reg   <= ACT_FRAME;
            for (int i = 0; i < 9; i++) frame_reg[i] <= 8'h00;
            for (int i = 0; i < 10; i++) uid_reg[i] <= 8'h00;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        in_reg <= in_data;
                end
                S_DECODE:
                begin
                    cidx_reg  <= 3'd0;
                    rx_sh_reg <= in_reg.reply_bytes;
                    if (in_reg.kind == KIND_START)
                    begin
                        for (int i = 0; i < 8; i++) uid_reg[i] <= in_reg.start_uid_head[8*i +: 8];
                        uid_reg[8] <= in_reg.start_uid_tail[7:0];
                        uid_reg[9] <= in_reg.start_uid_tail[15:8];
                        exp_reg    <= in_reg.start_uid_size;
                        sbits_reg  <= in_reg.start_known_bits;
                        level_reg  <= 2'd1;
                        busy_reg   <= !dec_fin;
                        res_act_reg  <= ACT_FINISH;
                        res_st_reg   <= dec_st;
                        res_size_reg <= in_reg.start_uid_size;
                        res_sak_reg  <= 8'h00;
                    end
                    else if (busy_reg && dec_fin)
                    begin
                        busy_reg     <= 1'b0;
                        res_act_reg  <= ACT_FINISH;
                        res_st_reg   <= dec_st;
                        res_size_reg <= exp_reg;
                        res_sak_reg  <= 8'h00;
                    end
                end
                S_COPY:
                begin
                    if (cidx_reg == in_reg.reply_count)
                    begin
                        slb_reg <= in_reg.reply_last_bits;
                    end
                    else
                    begin
                        // first byte keeps the bits already sent in the partial byte
                        if (cidx_reg == 3'd0)
                            frame_reg[widx] <= (frame_reg[widx] & ~cmask) | (rx_sh_reg[7:0] & cmask);
                        else
                            frame_reg[widx] <= rx_sh_reg[7:0];
                        rx_sh_reg <= rx_sh_reg >> 8;
                        cidx_reg  <= cidx_reg + 3'd1;
                    end
                end
                S_RESOLVE:
                begin
                    ccnt_reg <= 6'd0;
                    if (in_reg.reply_status == RS_COLL)
                    begin
                        if (!res_fin)
                        begin
                            lkb_reg         <= pos;
                            frame_reg[pidx] <= frame_reg[pidx] | (8'h01 << pbit);
                        end
                    end
                    else if (!sel_full)
                    begin
                        lkb_reg <= FULL_BITS;
                    end
                    else
                    begin
                        // store the uid bytes of this level, skipping a cascade tag
                        for (int i = 0; i < 4; i++)
                        begin
                            if (frame_reg[2] != TAG_CT || i < 3)
                                uid_reg[base + 4'(i)] <= (frame_reg[2] == TAG_CT)
                                                         ? frame_reg[3 + i] : frame_reg[2 + i];
                        end
                    end
                    if (res_fin)
                    begin
                        busy_reg     <= 1'b0;
                        res_act_reg  <= ACT_FINISH;
                        res_st_reg   <= res_st;
                        res_size_reg <= exp_reg;
                        res_sak_reg  <= 8'h00;
                    end
                end
                S_SETUP:
                begin
                    for (int i = 0; i < 9; i++) frame_reg[i] <= setup_frame[i];
                    lkb_reg <= known_ct[5:0];
                end
                S_EMIT:
                begin
                    ccnt_reg <= 6'd0;
                    slb_reg  <= tx;
                    res_act_reg <= ACT_FRAME;
                    if (sel_full)
                    begin
                        frame_reg[1] <= NVB_SELECT;
                        frame_reg[6] <= frame_reg[2] ^ frame_reg[3] ^ frame_reg[4] ^ frame_reg[5];
                    end
                    else
                    begin
                        frame_reg[1] <= {fidx, 1'b0, tx};
                    end
                end
                S_CRC:
                begin
                    ccnt_reg <= ccnt_reg + 6'd1;
                end
                S_CRC_END:
                begin
                    frame_reg[7] <= crc[7:0];
                    frame_reg[8] <= crc[15:8];
                end
                S_SAK_CRC:
                begin
                    ccnt_reg <= ccnt_reg + 6'd1;
                end
                S_SAK_CHK:
                begin
                    res_act_reg  <= ACT_FINISH;
                    res_sak_reg  <= 8'h00;
                    if (sak_bad_crc)
                    begin
                        busy_reg     <= 1'b0;
                        res_st_reg   <= ST_CRC;
                        res_size_reg <= exp_reg;
                    end
                    else if (frame_reg[6][2])
                    begin
                        res_size_reg <= exp_reg;
                        if (level_reg >= 2'd3)
                        begin
                            busy_reg   <= 1'b0;
                            res_st_reg <= ST_INTERNAL;
                        end
                        else
                        begin
                            level_reg <= level_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        busy_reg     <= 1'b0;
                        res_st_reg   <= ST_OK;
                        res_size_reg <= 4'({2'b00, level_reg} * 4'd3 + 4'd1);
                        res_sak_reg  <= frame_reg[6];
                    end
                end
                S_OUT:
                begin
                    if (slot_free)
                        out_reg <= out_next;
                end
                default:
                begin
                    cidx_reg <= 3'd0;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_lkb_range: assert property (@(posedge clk) disable iff (!rst_n)
        lkb_reg <= FULL_BITS)
        else $error("level known bits beyond a full uid part");
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg != 2'd0)
        else $error("cascade level zero");
    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> state_reg == S_OUT)
        else $error("selection ended without a finished result");
`endif

endmodule

@@ test/cas_checker.sv @@
// checker for the cascade anticollision/select sequencer: watches both channels,
// predicts each result and compares; depends on cas_pkg
module cas_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_stall,
    input  cas_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_stall,
    input  cas_pkg::out_t out_data,
    output int            fail_count,
    output int            pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cas_pkg::*;

    out_t       expected_q[$];
    logic       sel_busy;
    logic [1:0] level;
    logic [5:0] lvl_bits;
    logic [7:0] frm[9];
    logic [7:0] uid[10];
    logic [3:0] exp_size;
    logic [2:0] last_bits;
    logic [7:0] known_total;

    assign pending = expected_q.size();

    function automatic logic [15:0] crc_a_calc(input int first, input int n);
        logic [15:0] c;
        c = CRC_PRESET;
        for (int i = 0; i < n; i++) begin
            c = c ^ {8'h00, frm[first + i]};
            for (int b = 0; b < 8; b++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic out_t finish_res(input logic [2:0] st, input logic [3:0] sz,
                                        input logic [7:0] sk);
        out_t r;
        r = '0;
        r.action = ACT_FINISH;
        r.status = st;
        for (int i = 0; i < 8; i++) r.uid_head[8*i +: 8] = uid[i];
        r.uid_tail = {uid[9], uid[8]};
        r.uid_size = sz;
        r.sak = sk;
        sel_busy = 1'b0;
        return r;
    endfunction

    function automatic int level_base();
        return level == 1 ? 0 : (level == 2 ? 3 : 6);
    endfunction

    function automatic void setup_level();
        int base, known, idx, nb, maxb;
        logic ct;
        base = level_base();
        idx = 2;
        for (int i = 0; i < 9; i++) frm[i] = 8'h00;
        frm[0] = level == 1 ? CMD_SEL_CL1 : (level == 2 ? CMD_SEL_CL2 : CMD_SEL_CL3);
        if (level == 1) ct = known_total != 0 && exp_size > 4;
        else if (level == 2) ct = known_total != 0 && exp_size > 7;
        else ct = 1'b0;
        known = known_total > 8 * base ? known_total - 8 * base : 0;
        if (ct) begin
            frm[idx] = TAG_CT;
            idx++;
        end
        nb = known / 8 + (known % 8 != 0);
        maxb = ct ? 3 : 4;
        if (nb > maxb) nb = maxb;
        for (int i = 0; i < nb; i++) begin
            frm[idx] = uid[base + i];
            idx++;
        end
        if (ct) known += 8;
        if (known > 32) known = 32;
        lvl_bits = 6'(known);
    endfunction

    function automatic out_t frame_res();
        out_t r;
        int used, tx, room, idx;
        logic [15:0] c;
        if (lvl_bits >= FULL_BITS) begin
            frm[1] = NVB_SELECT;
            frm[6] = frm[2] ^ frm[3] ^ frm[4] ^ frm[5];
            c = crc_a_calc(0, 7);
            frm[7] = c[7:0];
            frm[8] = c[15:8];
            tx = 0; used = 9; room = 3;
        end
        else begin
            tx = lvl_bits % 8;
            idx = 2 + lvl_bits / 8;
            frm[1] = 8'((idx << 4) + tx);
            used = idx + (tx != 0);
            room = 9 - idx;
        end
        last_bits = 3'(tx);
        r = '0;
        for (int i = 0; i < 8; i++)
            if (i < used) r.frame_head[8*i +: 8] = frm[i];
        r.frame_tail = used == 9 ? frm[8] : 8'h00;
        r.frame_bytes = 4'(used);
        r.tx_last_bits = 3'(tx);
        r.rx_align = 3'(tx);
        r.rx_room = 3'(room);
        return r;
    endfunction

    // returns 1 when the item yields a result
    function automatic bit next_result(input in_t d, output out_t r);
        int cnt, off, room, pos, idx, base, src, n;
        logic [7:0] m, rx;
        logic [15:0] c;
        r = '0;
        if (d.kind == KIND_START) begin
            for (int i = 0; i < 8; i++) uid[i] = d.start_uid_head[8*i +: 8];
            uid[8] = d.start_uid_tail[7:0];
            uid[9] = d.start_uid_tail[15:8];
            exp_size = d.start_uid_size;
            known_total = d.start_known_bits;
            level = 2'd1;
            sel_busy = 1'b1;
            if (known_total > MAX_BITS) begin
                r = finish_res(ST_BADARG, exp_size, 8'h00);
                return 1;
            end
            setup_level();
            r = frame_res();
            return 1;
        end
        if (!sel_busy) return 0;
        if (d.reply_status == RS_TIMEOUT) begin
            r = finish_res(ST_TIMEOUT, exp_size, 8'h00);
            return 1;
        end
        if (d.reply_status == RS_NOROOM) begin
            r = finish_res(ST_NOROOM, exp_size, 8'h00);
            return 1;
        end
        if (d.reply_status != RS_OK && d.reply_status != RS_COLL) begin
            r = finish_res(ST_ERROR, exp_size, 8'h00);
            return 1;
        end
        if (lvl_bits >= FULL_BITS) begin
            off = 6; room = 3;
        end
        else begin
            off = 2 + lvl_bits / 8; room = 9 - off;
        end
        cnt = int'(d.reply_count);
        if (cnt > room) begin
            r = finish_res(ST_NOROOM, exp_size, 8'h00);
            return 1;
        end
        for (int i = 0; i < cnt; i++) begin
            rx = d.reply_bytes[8*i +: 8];
            if (i == 0) begin
                m = 8'hFF << last_bits;
                frm[off] = (frm[off] & ~m) | (rx & m);
            end
            else frm[off + i] = rx;
        end
        last_bits = d.reply_last_bits;
        if (d.reply_status == RS_COLL) begin
            if (d.reply_coll_reg[5]) begin
                r = finish_res(ST_COLL, exp_size, 8'h00);
                return 1;
            end
            pos = int'(d.reply_coll_reg[4:0]);
            if (pos == 0) pos = 32;
            if (pos <= lvl_bits) begin
                r = finish_res(ST_INTERNAL, exp_size, 8'h00);
                return 1;
            end
            lvl_bits = 6'(pos);
            idx = 1 + pos / 8 + (pos % 8 != 0);
            frm[idx][(pos - 1) % 8] = 1'b1;
            r = frame_res();
            return 1;
        end
        if (lvl_bits < FULL_BITS) begin
            lvl_bits = FULL_BITS;
            r = frame_res();
            return 1;
        end
        base = level_base();
        src = frm[2] == TAG_CT ? 3 : 2;
        n = frm[2] == TAG_CT ? 3 : 4;
        for (int i = 0; i < n; i++) uid[base + i] = frm[src + i];
        if (cnt != 3 || last_bits != 0) begin
            r = finish_res(ST_ERROR, exp_size, 8'h00);
            return 1;
        end
        c = crc_a_calc(6, 1);
        if (frm[7] != c[7:0] || frm[8] != c[15:8]) begin
            r = finish_res(ST_CRC, exp_size, 8'h00);
            return 1;
        end
        if (frm[6][2]) begin
            if (level >= 3) begin
                r = finish_res(ST_INTERNAL, exp_size, 8'h00);
                return 1;
            end
            level++;
            setup_level();
            r = frame_res();
            return 1;
        end
        r = finish_res(ST_OK, 4'(3 * level + 1), frm[6]);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_t r, e;
        if (!rst_n) begin
            fail_count <= 0;
            expected_q.delete();
            sel_busy = 1'b0;
            level = 2'd1;
            lvl_bits = '0;
            exp_size = '0;
            last_bits = '0;
            known_total = '0;
            for (int i = 0; i < 9; i++) frm[i] = 8'h00;
            for (int i = 0; i < 10; i++) uid[i] = 8'h00;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, out_data);
                    fail_count <= fail_count + 1;
                end
                else begin
                    e = expected_q.pop_front();
                    if (out_data !== e) begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, e, out_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                if (next_result(in_data, r)) expected_q.push_back(r);
        end
    end
endmodule

@@ test/tb_top.sv @@
// top of the sequencer testbench: clock, reset, stimulus and verdict
// depends on cas_pkg, cas_checker and cascade_anticollision_select_top
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cas_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic  clk, rst_n;
    logic  in_valid, in_stall, out_valid, out_stall;
    in_t   in_data;
    out_t  out_data;
    int    fail_count, pending;
    int    send_idle_pct, recv_stall_pct;
    int    quiet_cycles;

    cascade_anticollision_select_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    cas_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver stall
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** cascade_anticollision_select_top: FAILED **");
            $finish;
        end
    end

    // valid stays high into the next item unless the sender idles
    task automatic send_item(input in_t d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic in_t start_item(input int bits, input int sz);
        in_t d;
        d = '0;
        d.kind = KIND_START;
        d.start_known_bits = 8'(bits);
        d.start_uid_size = 4'(sz);
        d.start_uid_head = {$urandom, $urandom};
        d.start_uid_tail = 16'($urandom);
        d.reply_status = 3'($urandom);
        d.reply_bytes = 56'({$urandom, $urandom});
        return d;
    endfunction

    function automatic in_t reply_item(input logic [2:0] st, input logic [7:0] cr,
                                       input int cnt, input int lb);
        in_t d;
        d = '0;
        d.kind = ~KIND_START;
        d.reply_status = st;
        d.reply_coll_reg = cr;
        d.reply_bytes = 56'({$urandom, $urandom});
        d.reply_count = 3'(cnt);
        d.reply_last_bits = 3'(lb);
        d.start_known_bits = 8'($urandom);
        d.start_uid_head = {$urandom, $urandom};
        return d;
    endfunction

    // sak reply with a valid crc_a; cascade bit set on request
    function automatic in_t sak_item(input logic casc);
        in_t d;
        logic [7:0] s;
        logic [15:0] c;
        s = 8'($urandom);
        s[2] = casc;
        c = CRC_PRESET ^ {8'h00, s};
        for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        d = reply_item(RS_OK, 8'h00, 3, 0);
        d.reply_bytes = {32'h0, c, s};
        return d;
    endfunction

    // a selection with random collisions and random reply byte counts
    task automatic run_selection();
        int sz, bits, lv, k;
        sz = $urandom_range(2) == 0 ? 4 : ($urandom_range(1) ? 7 : 10);
        bits = $urandom_range(3) == 0 ? 0 : $urandom_range(8 * sz);
        send_item(start_item(bits, sz));
        lv = sz == 4 ? 1 : (sz == 7 ? 2 : 3);
        for (int l = 0; l < lv; l++) begin
            k = $urandom_range(2);
            for (int i = 0; i < k; i++)
                send_item(reply_item(RS_COLL, 8'($urandom_range(31)), $urandom_range(5),
                                     $urandom_range(7)));
            send_item(reply_item(RS_OK, 8'h00, $urandom_range(5), 0));
            if ($urandom_range(9) == 0) send_item(sak_item(1'($urandom_range(1))));
            else send_item(sak_item(l < lv - 1));
        end
    endtask

    task automatic run_noise();
        in_t d;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        d = raw[$bits(in_t)-1:0];
        d.start_uid_size = 4'($urandom_range(10));
        d.reply_status = 3'($urandom_range(7));
        send_item(d);
    endtask

    initial
    begin
        int bits_pct[4];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reply while idle, bad argument, extremes, every status
        send_item(reply_item(RS_OK, 8'h00, 0, 0));
        send_item(start_item(255, 15));
        send_item(start_item(81, 10));
        send_item(start_item(80, 10));
        send_item(reply_item(RS_TIMEOUT, 8'h00, 0, 0));
        send_item(start_item(0, 4));
        send_item(reply_item(RS_COLL, 8'h20, 2, 3));
        send_item(start_item(0, 4));
        send_item(reply_item(RS_COLL, 8'h00, 7, 0));
        send_item(start_item(12, 7));
        send_item(reply_item(RS_COLL, 8'h05, 2, 0));
        send_item(start_item(0, 4));
        send_item(reply_item(RS_COLL, 8'hDF, 4, 7));
        send_item(reply_item(RS_OK, 8'h00, 0, 0));
        send_item(reply_item(RS_OK, 8'h00, 2, 0));
        send_item(start_item(40, 10));
        send_item(reply_item(RS_ERROR, 8'hFF, 7, 7));
        send_item(start_item(80, 10));
        send_item(reply_item(RS_NOROOM, 8'h00, 0, 0));
        send_item(start_item(64, 10));
        send_item(reply_item(RS_RESERVED, 8'h00, 0, 0));
        send_item(start_item(32, 4));
        send_item(reply_item(RS_OK, 8'h00, 3, 0));
        send_item(start_item(80, 10));
        send_item(reply_item(RS_OK, 8'h00, 3, 5));

        bits_pct = '{0, 83, 0, 23};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = bits_pct[ph];
            recv_stall_pct = ph == 2 ? 83 : bits_pct[ph] == 23 ? 23 : 0;
            for (int n = 0; n < 45; n++) begin
                if ($urandom_range(4) == 0) run_noise();
                else run_selection();
            end
        end
        in_valid <= 1'b0;
        send_idle_pct = 0;
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("** cascade_anticollision_select_top: PASSED **");
        else
            $display("** cascade_anticollision_select_top: FAILED **");
        $finish;
    end
endmodule
